// ----- hw/rtl/torq_pkg.sv -----
// Shared types and codes for the timestamp-ordered request queue.
package torq_pkg;

   localparam int StampW = 32;
   localparam int RankW  = 8;
   localparam int CatW   = 4;
   localparam int DestW  = 8;
   localparam int WinW   = 5;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_MISS = 2'd2;

   typedef struct packed {
      logic [StampW-1:0] stamp;
      logic [RankW-1:0]  rank;
      logic [CatW-1:0]   category;
      logic [DestW-1:0]  destination;
   } entry_type;

   // Broadcast from the sequencer to every cell.
   typedef struct packed {
      logic      start;   // reload the walk mask
      logic      step;    // move the token one cell down
      logic      ins;     // commit an insert
      logic      rem;     // commit a removal at the token
      entry_type key;
   } cmd_type;

   // What each cell reports back about itself.
   typedef struct packed {
      logic after;     // live and key sorts after the request key
      logic tok;       // token sits here
      logic rank_hit;
      logic dst_hit;
      logic cat_diff;
   } flag_type;

endpackage

// ----- hw/rtl/torq_cell.sv -----
// One queue slot: holds an entry, shifts to or from its neighbours, carries the walk mask.
module torq_cell
   import torq_pkg::*;
(
   input  logic      clock,
   input  cmd_type   cmd,
   input  logic      live_self,
   input  logic      live_prev,
   input  logic      after_prev,
   input  logic      walk_prev,
   input  entry_type prev_entry,
   input  entry_type next_entry,
   output entry_type entry,
   output logic      walk,
   output flag_type  flags
);

   entry_type entry_ff, entry_in;
   logic      walk_ff, walk_in;
   logic      key_after;
   logic      ins_here;

   assign key_after = (entry_ff.stamp > cmd.key.stamp) ||
                      ((entry_ff.stamp == cmd.key.stamp) && (entry_ff.rank > cmd.key.rank));

   // New entry lands in the first slot that sorts after it, or just past the tail.
   assign ins_here = !after_prev &&
                     ((live_self && key_after) || (live_prev && !live_self));

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins) begin
         if (after_prev) begin
            entry_in = prev_entry;
         end else if (ins_here) begin
            entry_in = cmd.key;
         end
      end else if (cmd.rem && walk_ff) begin
         entry_in = next_entry;
      end
   end

   always_comb begin
      walk_in = walk_ff;
      if (cmd.start) begin
         walk_in = 1'b1;
      end else if (cmd.step) begin
         walk_in = walk_prev;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      walk_ff  <= walk_in;
   end

   assign entry          = entry_ff;
   assign walk           = walk_ff;
   assign flags.after    = live_self && key_after;
   assign flags.tok      = walk_ff && !walk_prev;
   assign flags.rank_hit = (entry_ff.rank == cmd.key.rank);
   assign flags.dst_hit  = (entry_ff.destination == cmd.key.destination);
   assign flags.cat_diff = (entry_ff.category != cmd.key.category);

endmodule

// ----- hw/rtl/timestamp_ordered_request_queue_unit.sv -----
// Top level: request sequencer driving a chain of sorted queue cells.
// Insert: result registered from the work state once the result register is free.
// Remove and query: a token walks the chain one cell per cycle; one request is worked on at a time,
// the next is taken the cycle after its result is loaded.
// The result register lets a new request in while the previous result waits.
// Reset clears the entry count and control; stored entries are not cleared.
module timestamp_ordered_request_queue_unit
   import torq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
)
(
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_opcode,
   input  logic [StampW-1:0]                  req_stamp,
   input  logic [RankW-1:0]                   req_rank,
   input  logic [CatW-1:0]                    req_category,
   input  logic [DestW-1:0]                   req_destination,
   input  logic [WinW-1:0]                    req_window,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_found,
   output logic [1:0]                         rsp_status,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]   rsp_occupancy
);

   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WORK = 1'b1;

   logic            state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in, count_nx;
   logic [1:0]      op_ff;
   logic [WinW-1:0] win_ff;
   logic [WinW-1:0] seen_ff, seen_in;
   entry_type       key_ff;

   logic            rsp_valid_ff;
   logic            found_ff;
   logic [1:0]      status_ff;
   logic [CntW-1:0] occ_ff;

   cmd_type   cmd;
   entry_type entries [QUEUE_DEPTH];
   flag_type  flags   [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] walk, live, tok, rank_hit, dst_hit, cat_diff, next_dst;

   logic accept, slot_free, finish;
   logic done, ins_go, rem_go, step_go, found_nx;
   logic [1:0] status_nx;
   logic cur_live, cur_rank, cur_dst, cur_cat, nxt_dst;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   genvar g;
   generate
      for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
         logic      lp, ap, wp;
         entry_type pe, ne;

         if (g == 0) begin : g_head
            assign lp = 1'b1;
            assign ap = 1'b0;
            assign wp = 1'b0;
            assign pe = '0;
         end else begin : g_body
            assign lp = live[g-1];
            assign ap = flags[g-1].after;
            assign wp = walk[g-1];
            assign pe = entries[g-1];
         end

         if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign ne          = '0;
            assign next_dst[g] = 1'b0;
         end else begin : g_mid
            assign ne          = entries[g+1];
            assign next_dst[g] = tok[g] && live[g+1] && dst_hit[g+1];
         end

         assign live[g]     = (CntW'(g) < count_ff);
         assign tok[g]      = flags[g].tok;
         assign rank_hit[g] = flags[g].rank_hit;
         assign dst_hit[g]  = flags[g].dst_hit;
         assign cat_diff[g] = flags[g].cat_diff;

         torq_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .live_self  (live[g]),
            .live_prev  (lp),
            .after_prev (ap),
            .walk_prev  (wp),
            .prev_entry (pe),
            .next_entry (ne),
            .entry      (entries[g]),
            .walk       (walk[g]),
            .flags      (flags[g])
         );
      end
   endgenerate

   // Token cell view
   assign cur_live = |(tok & live);
   assign cur_rank = |(tok & live & rank_hit);
   assign cur_dst  = |(tok & live & dst_hit);
   assign cur_cat  = |(tok & live & cat_diff);
   assign nxt_dst  = |next_dst;

   always_comb begin
      done      = 1'b0;
      ins_go    = 1'b0;
      rem_go    = 1'b0;
      step_go   = 1'b0;
      found_nx  = 1'b0;
      status_nx = STATUS_OK;
      count_nx  = count_ff;
      unique case (op_ff)
         OP_INSERT: begin
            done = 1'b1;
            if (count_ff == CntW'(QUEUE_DEPTH)) begin
               status_nx = STATUS_FULL;
            end else begin
               ins_go   = 1'b1;
               count_nx = count_ff + CntW'(1);
            end
         end
         OP_REMOVE: begin
            if (!cur_live) begin
               done      = 1'b1;
               status_nx = STATUS_MISS;
            end else if (cur_rank) begin
               done     = 1'b1;
               rem_go   = 1'b1;
               count_nx = count_ff - CntW'(1);
            end else begin
               step_go = 1'b1;
            end
         end
         OP_QUERY: begin
            priority if (!cur_live || (seen_ff >= win_ff)) begin
               done = 1'b1;
            end else if (cur_dst && cur_cat) begin
               done = 1'b1;
            end else if (cur_rank) begin
               done     = 1'b1;
               found_nx = 1'b1;
            end else begin
               step_go = 1'b1;
            end
         end
         default: begin
            done = 1'b1;
         end
      endcase
   end

   assign finish = (state_ff == ST_WORK) && done && slot_free;

   assign cmd.start = accept;
   assign cmd.step  = (state_ff == ST_WORK) && step_go;
   assign cmd.ins   = finish && ins_go;
   assign cmd.rem   = finish && rem_go;
   assign cmd.key   = key_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      seen_in  = seen_ff;
      if (accept) begin
         state_in = ST_WORK;
         seen_in  = '0;
      end else if (finish) begin
         state_in = ST_IDLE;
         count_in = count_nx;
      end else if (cmd.step) begin
         seen_in = seen_ff + {{(WinW-1){1'b0}}, nxt_dst};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      seen_ff <= seen_in;
      if (accept) begin
         op_ff              <= req_opcode;
         win_ff             <= req_window;
         key_ff.stamp       <= req_stamp;
         key_ff.rank        <= req_rank;
         key_ff.category    <= req_category;
         key_ff.destination <= req_destination;
      end
      if (finish) begin
         found_ff  <= found_nx;
         status_ff <= status_nx;
         occ_ff    <= count_nx;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = found_ff;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = occ_ff;

endmodule

// ----- tb/sv/torq_result_checker.sv -----
// Checker for the request queue: tracks the sorted table, predicts each response and compares.
module torq_result_checker
   import torq_pkg::*;
#(
   parameter int Depth = 16,
   parameter int OccW  = $clog2(Depth+1)
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [1:0]        req_opcode,
   input  logic [StampW-1:0] req_stamp,
   input  logic [RankW-1:0]  req_rank,
   input  logic [CatW-1:0]   req_category,
   input  logic [DestW-1:0]  req_destination,
   input  logic [WinW-1:0]   req_window,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic              rsp_found,
   input  logic [1:0]        rsp_status,
   input  logic [OccW-1:0]   rsp_occupancy,
   output int                mismatches,
   output int                outstanding,
   output int                checked,
   output int                full_drops,
   output int                misses,
   output int                hits
);

   typedef struct packed {
      logic            found;
      logic [1:0]      status;
      logic [OccW-1:0] occupancy;
   } answer_type;

   // shadow of the sorted request table, head at index 0
   entry_type  slots [Depth];
   int         fill;
   answer_type answers_due [$];
   answer_type want;
   int         err_count, check_count, full_count, miss_count, hit_count;

   function automatic answer_type serve_request(input logic [1:0] op,
                                                input entry_type req,
                                                input logic [WinW-1:0] win);
      answer_type ans;
      int         pos, i, counted;
      bit         done;
      ans = '0;
      case (op)
         OP_INSERT: begin
            if (fill >= Depth) begin
               ans.status = STATUS_FULL;
            end else begin
               // new entry goes after every entry with an equal key
               pos = fill;
               for (i = 0; i < fill; i++)
                  if (pos == fill && (slots[i].stamp > req.stamp ||
                      (slots[i].stamp == req.stamp && slots[i].rank > req.rank)))
                     pos = i;
               for (i = fill; i > pos; i--)
                  slots[i] = slots[i-1];
               slots[pos] = req;
               fill++;
            end
         end
         OP_REMOVE: begin
            pos = fill;
            for (i = 0; i < fill; i++)
               if (pos == fill && slots[i].rank == req.rank)
                  pos = i;
            if (pos == fill) begin
               ans.status = STATUS_MISS;
            end else begin
               for (i = pos; i + 1 < fill; i++)
                  slots[i] = slots[i+1];
               fill--;
            end
         end
         OP_QUERY: begin
            i = 0;
            counted = 0;
            done = 1'b0;
            while (!done && i < fill && counted < int'(win)) begin
               if (slots[i].destination == req.destination &&
                   slots[i].category != req.category) begin
                  done = 1'b1;
               end else if (slots[i].rank == req.rank) begin
                  ans.found = 1'b1;
                  done = 1'b1;
               end else begin
                  i++;
                  if (i < fill && slots[i].destination == req.destination)
                     counted++;
               end
            end
         end
         default: ;
      endcase
      ans.occupancy = OccW'(fill);
      return ans;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         fill = 0;
         answers_due.delete();
      end else begin
         // response side first: a transfer here always belongs to an older request
         if (rsp_valid && !rsp_stall) begin
            check_count++;
            if (answers_due.size() == 0) begin
               err_count++;
               $error("response with nothing pending: found %0d status %0d occupancy %0d",
                      rsp_found, rsp_status, rsp_occupancy);
            end else begin
               want = answers_due.pop_front();
               if (rsp_found !== want.found) begin
                  err_count++;
                  $error("found: expected %0d, got %0d", want.found, rsp_found);
               end
               if (rsp_status !== want.status) begin
                  err_count++;
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
               end
               if (rsp_occupancy !== want.occupancy) begin
                  err_count++;
                  $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_occupancy);
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = serve_request(req_opcode,
                                 '{stamp: req_stamp, rank: req_rank,
                                   category: req_category, destination: req_destination},
                                 req_window);
            answers_due.push_back(want);
            if (want.status == STATUS_FULL) full_count++;
            if (want.status == STATUS_MISS) miss_count++;
            if (want.found) hit_count++;
         end
      end
      mismatches  <= err_count;
      outstanding <= answers_due.size();
      checked     <= check_count;
      full_drops  <= full_count;
      misses      <= miss_count;
      hits        <= hit_count;
   end

endmodule

// ----- tb/sv/tb_timestamp_ordered_request_queue_unit.sv -----
// Testbench top: clock, reset, request and response traffic, watchdog and verdict.
module tb_timestamp_ordered_request_queue_unit;
   import torq_pkg::*;

   localparam int         Depth      = 16;
   localparam int         OccW       = $clog2(Depth+1);
   localparam int         QuietLimit = 2000;
   localparam int         ItemCount  = 550;
   localparam logic [1:0] OP_SPARE   = 2'd3;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_opcode = OP_INSERT;
   logic [StampW-1:0] req_stamp = '0;
   logic [RankW-1:0]  req_rank = '0;
   logic [CatW-1:0]   req_category = '0;
   logic [DestW-1:0]  req_destination = '0;
   logic [WinW-1:0]   req_window = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_found;
   logic [1:0]        rsp_status;
   logic [OccW-1:0]   rsp_occupancy;

   int mismatches, outstanding, checked, full_drops, misses, hits;
   bit eager = 1'b0;   // sender offers back to back while set

   timestamp_ordered_request_queue_unit #(.QUEUE_DEPTH(Depth)) DUT (.*);

   torq_result_checker #(.Depth(Depth)) u_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic offer(input logic [1:0] op, input logic [StampW-1:0] st,
                        input logic [RankW-1:0] rk, input logic [CatW-1:0] cat,
                        input logic [DestW-1:0] dst, input logic [WinW-1:0] win);
      int unsigned gap;
      gap = eager ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_stamp       <= st;
      req_rank        <= rk;
      req_category    <= cat;
      req_destination <= dst;
      req_window      <= win;
      do @(posedge clock); while (req_stall);
   endtask

   // receiver: random hold-offs, calm stretches, and one long hold to back up the block
   initial begin : drain
      int unsigned hold, taken;
      bit          calm;
      taken = 0;
      calm  = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (taken % 32 == 0)
            calm = ($urandom_range(0, 2) == 0);
         hold = calm ? 0 : $urandom_range(0, 14);
         if (taken == 120)
            hold = 400;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QuietLimit) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no transfer for %0d cycles", QuietLimit);
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      int                useful, n, ins_pct, i;
      logic [1:0]        op;
      logic [StampW-1:0] st;
      logic [RankW-1:0]  rk;
      logic [CatW-1:0]   cat;
      logic [DestW-1:0]  dst;
      logic [WinW-1:0]   win;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, equal keys, fill to full, a drop when full, query and remove special cases
      offer(OP_INSERT, 32'h0000_0000, 8'd0, 4'd0, 8'd0, 5'd0);
      offer(OP_INSERT, 32'hFFFF_FFFF, 8'd255, 4'd15, 8'd255, 5'd31);
      offer(OP_INSERT, 32'd5, 8'd3, 4'd1, 8'd0, 5'd0);
      offer(OP_INSERT, 32'd5, 8'd3, 4'd2, 8'd1, 5'd0);
      offer(OP_INSERT, 32'd5, 8'd2, 4'd0, 8'd0, 5'd0);
      offer(OP_INSERT, 32'd5, 8'd4, 4'd1, 8'd0, 5'd0);
      for (i = 0; i < 10; i++)
         offer(OP_INSERT, 32'h5555_5555 + i, 8'hAA ^ 8'(i), 4'(i), 8'h55 + 8'(i), 5'd0);
      offer(OP_INSERT, 32'd7, 8'd9, 4'd0, 8'd0, 5'd0);        // dropped, table full
      offer(OP_QUERY, 32'd0, 8'd0, 4'd0, 8'd0, 5'd0);         // zero window
      offer(OP_QUERY, 32'd0, 8'd255, 4'd0, 8'd7, 5'd16);      // found at the tail
      offer(OP_QUERY, 32'd0, 8'd4, 4'd1, 8'd0, 5'd31);        // same destination, other category
      offer(OP_QUERY, 32'd0, 8'd200, 4'd0, 8'd9, 5'd16);      // runs off the end
      offer(OP_REMOVE, 32'd0, 8'd77, 4'd0, 8'd0, 5'd0);       // rank not held
      offer(OP_REMOVE, 32'd0, 8'd3, 4'd0, 8'd0, 5'd0);
      offer(OP_SPARE, 32'hFFFF_FFFF, 8'd255, 4'd15, 8'd255, 5'd31);
      offer(OP_REMOVE, 32'd0, 8'd0, 4'd0, 8'd0, 5'd0);

      // random: small pools for ranks, stamps and destinations so keys tie and queries hit
      useful  = 0;
      n       = 0;
      ins_pct = 50;
      while (useful < ItemCount) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: ins_pct = 15;
               1: ins_pct = 50;
               default: ins_pct = 85;
            endcase
            eager = ($urandom_range(0, 3) == 0);
         end
         if ($urandom_range(0, 99) < ins_pct)
            op = OP_INSERT;
         else
            case ($urandom_range(0, 19))
               0: op = OP_SPARE;
               1, 2, 3, 4, 5, 6, 7, 8: op = OP_REMOVE;
               default: op = OP_QUERY;
            endcase
         st  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15);
         rk  = ($urandom_range(0, 7) == 0) ? RankW'($urandom_range(0, 255))
                                           : RankW'($urandom_range(0, 7));
         cat = ($urandom_range(0, 3) == 0) ? CatW'($urandom_range(0, 15))
                                           : CatW'($urandom_range(0, 1));
         dst = ($urandom_range(0, 3) == 0) ? DestW'($urandom_range(0, 255))
                                           : DestW'($urandom_range(0, 2));
         win = ($urandom_range(0, 7) == 0) ? WinW'($urandom_range(0, 31))
                                           : WinW'($urandom_range(0, 16));
         offer(op, st, rk, cat, dst, win);
         n++;
         if (op != OP_SPARE)
            useful++;
      end
      req_valid <= 1'b0;

      // let the checker count the last transfer before watching the pending total
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (Depth + 4) @(posedge clock);

      $display("Run covered %0d responses: %0d inserts refused on a full table,", checked,
               full_drops);
      $display("%0d removes of absent ranks, %0d queries answered found.", misses, hits);
      if (mismatches == 0 && outstanding == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/torq_pkg.sv
hw/rtl/torq_cell.sv
hw/rtl/timestamp_ordered_request_queue_unit.sv
tb/sv/torq_result_checker.sv
tb/sv/tb_timestamp_ordered_request_queue_unit.sv
